// File: rtl/core/ncdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncdf_pkg
// Shared constants and types for the normal CDF approximation pipeline.
// ----------------------------------------------------------------------------
package ncdf_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // internal fraction bits (Q30 datapath)
    localparam int WB = 30;

    typedef logic [30:0]        qval_t;   // unsigned Q30, 0 .. 1.0
    typedef logic [28:0]        pdf_t;    // density, always below 0.5
    typedef logic signed [33:0] poly_t;   // Horner partial sum

    localparam qval_t Q_ONE = 31'h4000_0000;
    localparam longint unsigned Q_HALF = 64'd1 << (WB - 1);

    localparam logic [27:0]        C_GAMMA        = 28'd248723596;
    localparam logic signed [31:0] C_A1           = 32'sd342933307;
    localparam logic signed [31:0] C_A2           = -32'sd382857446;
    localparam logic signed [31:0] C_A3           = 32'sd1912847369;
    localparam logic signed [31:0] C_A4           = -32'sd1955558716;
    localparam logic signed [31:0] C_A5           = 32'sd1428371292;
    localparam logic [28:0]        C_INV_SQRT_2PI = 29'd428361012;
    localparam logic [28:0]        C_EXP_M1       = 29'd395007542;

    // floor(v/6) == (v*43)>>8 for v in 0..64
    localparam logic [5:0] RECIP6 = 6'd43;

    localparam int SQ_STEPS   = 8;        // squarings of the seed
    localparam int EXP_STEPS  = 32;       // max integer part of x*x/2
    localparam int DIV_STEPS  = WB + 1;   // quotient bits of the reciprocal
    localparam int POLY_STEPS = 5;
    localparam int EXP_LAT    = 2 + SQ_STEPS + EXP_STEPS + 1;
    localparam int POLY_DLY   = EXP_LAT - DIV_STEPS - POLY_STEPS;

    localparam logic signed [31:0] POLY_ADD [POLY_STEPS] =
        '{C_A4, C_A3, C_A2, C_A1, 32'sd0};

endpackage

// File: rtl/core/normal_cdf_approx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// normal_cdf_approx_core
// Standard normal CDF of a Q4.F argument, polynomial tail approximation.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries arg_x (signed Q4.FRAC_BITS).
//   Output channel out_valid/out_ready carries probability (Q1.FRAC_BITS,
//   0 to 1.0 inclusive). One result beat per input beat, in order.
//   Throughput: one beat per cycle while the skid register is empty. The
//   reciprocal is a 31-stage divider and the exponential a 43-stage chain of
//   multipliers; they run side by side and the exponential sets the depth.
//   Every stage advances together; an output register plus a one-entry skid
//   register sit behind the last stage, so a new beat is still taken on the
//   cycle a finished result first stalls. in_ready drops only once the skid
//   register holds a beat, and no beat is lost or repeated across a stall.
//   Reset clears all valid bits; the pipeline holds no other state.
// ----------------------------------------------------------------------------
module normal_cdf_approx_core #(
    parameter int FRAC_BITS = ncdf_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [FRAC_BITS+3:0] arg_x,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [FRAC_BITS:0]          probability
);
    import ncdf_pkg::*;

    localparam int IN_W   = FRAC_BITS + 4;
    localparam int OUT_W  = FRAC_BITS + 1;
    localparam int SH     = WB - FRAC_BITS;
    localparam int GM_W   = 28 + IN_W;
    localparam int SQ_W   = 2 * IN_W;
    localparam int STAGES = 2 + EXP_LAT + 2;

    logic              en;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-3:0] neg_reg;

    logic [IN_W-1:0]   mag;
    logic [GM_W-1:0]   gm_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [61:0]       gm_wide;
    logic [67:0]       sq_wide;
    logic [31:0]       d_next;
    logic [31:0]       d_reg;
    logic [35:0]       t_reg;

    qval_t             k_div;
    pdf_t              pdf;
    poly_t             p_reg  [POLY_STEPS];
    qval_t             k_reg  [POLY_STEPS];
    poly_t             pd_reg [POLY_DLY];

    logic [32:0]       pc;
    logic [61:0]       tprod;
    logic [31:0]       tail_full;
    qval_t             tail;
    qval_t             prob_next;
    qval_t             prob_reg;
    logic [31:0]       r2;
    logic [OUT_W-1:0]  res_reg;

    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_prob_reg, out_prob_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [OUT_W-1:0]  skid_prob_reg, skid_prob_next;
    logic              pipe_fire;

    assign en       = !skid_valid_reg;
    assign in_ready = en;

    // stage 1: magnitude, gamma*|x| and |x|^2
    assign mag = arg_x[IN_W-1] ? IN_W'(~arg_x + 1'b1) : IN_W'(arg_x);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            gm_reg <= GM_W'(C_GAMMA) * GM_W'(mag);
            sq_reg <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    // stage 2: divisor 1 + gamma*|x| and t = x*x/2, both Q30
    always_comb
    begin
        gm_wide = 62'(gm_reg) << SH;
        d_next  = 32'(Q_ONE) + 32'((gm_wide + 62'(Q_HALF)) >> WB);
        sq_wide = 68'(sq_reg) << (2 * SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
            t_reg <= 36'(sq_wide >> 31);
        end
    end

    ncdf_div u_div (
        .clk (clk),
        .en  (en),
        .dvs (d_reg),
        .quo (k_div)
    );

    ncdf_exp u_exp (
        .clk (clk),
        .en  (en),
        .t   (t_reg),
        .pdf (pdf)
    );

    // Horner in k, one sign-magnitude multiply per stage
    genvar i;
    generate
        for (i = 0; i < POLY_STEPS; i++)
        begin : g_poly
            poly_t       p_src;
            qval_t       k_src;
            logic [33:0] pm;
            logic [64:0] pp;
            logic [33:0] pr;
            poly_t       pn;

            if (i == 0)
            begin : g_first
                assign p_src = 34'(C_A5);
                assign k_src = k_div;
            end
            else
            begin : g_rest
                assign p_src = p_reg[i-1];
                assign k_src = k_reg[i-1];
            end

            always_comb
            begin
                pm = p_src[33] ? 34'(-p_src) : 34'(p_src);
                pp = 65'(pm) * 65'(k_src) + 65'(Q_HALF);
                pr = pp[63:30];
                pn = p_src[33] ? -$signed(pr) : $signed(pr);
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    p_reg[i] <= pn + 34'(POLY_ADD[i]);
                    k_reg[i] <= k_src;
                end
            end
        end

        for (i = 0; i < POLY_DLY; i++)
        begin : g_dly
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    pd_reg[i] <= (i == 0) ? p_reg[POLY_STEPS-1] : pd_reg[(i == 0) ? 0 : i-1];
                end
            end
        end
    endgenerate

    // tail = max(P,0) * pdf, clamped to one; mirror for negative x
    always_comb
    begin
        pc        = pd_reg[POLY_DLY-1][33] ? 33'd0 : 33'(pd_reg[POLY_DLY-1]);
        tprod     = 62'(pc) * 62'(pdf) + 62'(Q_HALF);
        tail_full = 32'(tprod >> WB);
        tail      = (tail_full > 32'(Q_ONE)) ? Q_ONE : 31'(tail_full);
        prob_next = neg_reg[STAGES-3] ? tail : Q_ONE - tail;
        r2        = 32'({prob_reg, 1'b0}) >> SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prob_reg <= prob_next;
            res_reg  <= OUT_W'((r2 + 32'd1) >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg_reg <= {neg_reg[STAGES-4:0], arg_x[IN_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // output register with one skid entry
    assign pipe_fire = vld_reg[STAGES-1] && en;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_prob_next   = out_prob_reg;
        skid_valid_next = skid_valid_reg;
        skid_prob_next  = skid_prob_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_prob_next   = skid_prob_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = pipe_fire;
                out_prob_next  = res_reg;
            end
        end
        else if (pipe_fire)
        begin
            skid_valid_next = 1'b1;
            skid_prob_next  = res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prob_reg  <= out_prob_next;
        skid_prob_reg <= skid_prob_next;
    end

    assign out_valid   = out_valid_reg;
    assign probability = out_prob_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[0])
        else $error("accepted beat missing from first stage");

    a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> probability <= (OUT_W'(1) << FRAC_BITS))
        else $error("probability above one");
`endif

endmodule

// File: rtl/core/ncdf_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncdf_div
// Pipelined restoring divider: quo = (2^60 + dvs/2) / dvs, one bit per stage.
// ----------------------------------------------------------------------------
module ncdf_div (
    input  logic          clk,
    input  logic          en,
    input  logic [31:0]   dvs,
    output ncdf_pkg::qval_t quo
);
    import ncdf_pkg::*;

    logic [31:0] rem_reg [DIV_STEPS];
    logic [31:0] d_reg   [DIV_STEPS];
    logic [30:0] q_reg   [DIV_STEPS];

    logic [31:0] rem_src [DIV_STEPS];
    logic [31:0] d_src   [DIV_STEPS];
    logic [30:0] q_src   [DIV_STEPS];

    genvar i;
    generate
        for (i = 0; i < DIV_STEPS; i++)
        begin : g_step
            logic [32:0] trial;
            logic        ge;
            logic [31:0] rem_next;
            logic [30:0] q_next;

            if (i == 0)
            begin : g_first
                // upper dividend bits reduce to 2^29, always below the divisor
                assign rem_src[i] = 32'h2000_0000;
                assign d_src[i]   = dvs;
                assign q_src[i]   = '0;
            end
            else
            begin : g_rest
                assign rem_src[i] = rem_reg[i-1];
                assign d_src[i]   = d_reg[i-1];
                assign q_src[i]   = q_reg[i-1];
            end

            // low dividend bits are dvs/2
            always_comb
            begin
                trial    = {rem_src[i], d_src[i][DIV_STEPS - i]};
                ge       = trial >= {1'b0, d_src[i]};
                rem_next = ge ? 32'(trial - {1'b0, d_src[i]}) : trial[31:0];
                q_next   = {q_src[i][29:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i] <= rem_next;
                    d_reg[i]   <= d_src[i];
                    q_reg[i]   <= q_next;
                end
            end
        end
    endgenerate

    assign quo = q_reg[DIV_STEPS-1];

endmodule

// File: rtl/core/ncdf_exp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ncdf_exp
// Pipelined density: exp(-t) / sqrt(2*pi) for t in Q30, t up to 32.
// ----------------------------------------------------------------------------
module ncdf_exp (
    input  logic         clk,
    input  logic         en,
    input  logic [35:0]  t,
    output ncdf_pkg::pdf_t pdf
);
    import ncdf_pkg::*;

    logic [21:0] s_reg;
    logic [14:0] s2_reg;
    logic [5:0]  n1_reg;
    qval_t       seed_e_reg;
    logic [5:0]  seed_n_reg;
    qval_t       sq_e_reg [SQ_STEPS];
    logic [5:0]  sq_n_reg [SQ_STEPS];
    qval_t       st_e_reg [EXP_STEPS];
    logic [5:0]  st_n_reg [EXP_STEPS];
    pdf_t        pdf_reg;

    logic [21:0] s_next;
    logic [44:0] s2_full;
    logic [14:0] s2_next;
    logic [36:0] s3_full;
    logic [6:0]  s3;
    logic [12:0] q6_full;
    logic [3:0]  q6;
    qval_t       seed_e_next;
    logic [61:0] pdf_full;

    // seed on the fraction scaled by 1/256: 1 - s + s^2/2 - s^3/6
    always_comb
    begin
        s_next      = t[29:8];
        s2_full     = 45'(s_next) * 45'(s_next) + 45'(Q_HALF);
        s2_next     = 15'(s2_full >> WB);
        s3_full     = 37'(s2_reg) * 37'(s_reg) + 37'(Q_HALF);
        s3          = 7'(s3_full >> WB);
        q6_full     = 13'(s3) * 13'(RECIP6);
        q6          = 4'(q6_full >> 8);
        seed_e_next = Q_ONE - 31'(s_reg) + 31'(s2_reg >> 1) - 31'(q6);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s_reg      <= s_next;
            s2_reg     <= s2_next;
            n1_reg     <= t[35:30];
            seed_e_reg <= seed_e_next;
            seed_n_reg <= n1_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < SQ_STEPS; i++)
        begin : g_sq
            qval_t       e_src;
            logic [5:0]  n_src;
            logic [61:0] prod;

            if (i == 0)
            begin : g_first
                assign e_src = seed_e_reg;
                assign n_src = seed_n_reg;
            end
            else
            begin : g_rest
                assign e_src = sq_e_reg[i-1];
                assign n_src = sq_n_reg[i-1];
            end

            assign prod = 62'(e_src) * 62'(e_src) + 62'(Q_HALF);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sq_e_reg[i] <= 31'(prod >> WB);
                    sq_n_reg[i] <= n_src;
                end
            end
        end

        // one factor of exp(-1) per unit of the integer part
        for (i = 0; i < EXP_STEPS; i++)
        begin : g_int
            qval_t       e_src;
            logic [5:0]  n_src;
            logic [59:0] prod;

            if (i == 0)
            begin : g_first
                assign e_src = sq_e_reg[SQ_STEPS-1];
                assign n_src = sq_n_reg[SQ_STEPS-1];
            end
            else
            begin : g_rest
                assign e_src = st_e_reg[i-1];
                assign n_src = st_n_reg[i-1];
            end

            assign prod = 60'(e_src) * 60'(C_EXP_M1) + 60'(Q_HALF);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_e_reg[i] <= (n_src > 6'(i)) ? 31'(prod >> WB) : e_src;
                    st_n_reg[i] <= n_src;
                end
            end
        end
    endgenerate

    assign pdf_full = 62'(st_e_reg[EXP_STEPS-1]) * 62'(C_INV_SQRT_2PI) + 62'(Q_HALF);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pdf_reg <= 29'(pdf_full >> WB);
        end
    end

    assign pdf = pdf_reg;

endmodule

// File: verif/tb_normal_cdf_approx_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normal_cdf_approx_core
// Checks the fixed-point normal CDF core beat by beat against a local
// integer model of the polynomial tail approximation, under random idling
// on both channels.
// ----------------------------------------------------------------------------
module tb_normal_cdf_approx_core;

    localparam int FB    = ncdf_pkg::FRAC_BITS_DEF;
    localparam int IW    = FB + 4;
    localparam int OW    = FB + 1;
    localparam int QW    = 30;
    localparam int DRAIN = 200;

    typedef longint unsigned u64_t;

    localparam u64_t ONE_Q  = u64_t'(1) << QW;
    localparam u64_t HALF_Q = u64_t'(1) << (QW - 1);

    localparam u64_t K_GAMMA = 64'd248723596;
    localparam longint K_A1 = 342933307;
    localparam longint K_A2 = -382857446;
    localparam longint K_A3 = 1912847369;
    localparam longint K_A4 = -1955558716;
    localparam longint K_A5 = 1428371292;
    localparam u64_t K_INV_SQ2PI = 64'd428361012;
    localparam u64_t K_EM1       = 64'd395007542;

    // ------------------------------------------------------------------
    // CDF model
    // ------------------------------------------------------------------
    function automatic u64_t qmul(u64_t a, u64_t b);
        return (a * b + HALF_Q) >> QW;
    endfunction

    function automatic longint qmul_s(longint a, u64_t b);
        bit   neg;
        u64_t m;
        u64_t r;
        neg = a < 0;
        m = neg ? u64_t'(-a) : u64_t'(a);
        r = (m * b + HALF_Q) >> QW;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic u64_t exp_of_neg(u64_t t);
        u64_t n;
        u64_t s;
        u64_t s2;
        u64_t s3;
        u64_t e;
        n = t >> QW;
        s = (t & (ONE_Q - 1)) >> 8;
        s2 = qmul(s, s);
        s3 = qmul(s2, s);
        e = ONE_Q - s + (s2 >> 1) - s3 / 6;
        for (int i = 0; i < 8; i++)
            e = qmul(e, e);
        while (n > 0 && e > 0)
        begin
            e = qmul(e, K_EM1);
            n--;
        end
        return e;
    endfunction

    function automatic logic [OW-1:0] normal_cdf(logic signed [IW-1:0] x);
        bit     neg;
        u64_t   mag;
        u64_t   ax;
        u64_t   d;
        u64_t   k;
        u64_t   hi;
        u64_t   lo;
        u64_t   t;
        u64_t   dens;
        longint p;
        u64_t   tail;
        u64_t   prob;
        neg = x[IW-1];
        mag = neg ? (u64_t'(1) << IW) - u64_t'(unsigned'(x)) : u64_t'(unsigned'(x));
        ax = mag << (QW - FB);
        d = ONE_Q + qmul(K_GAMMA, ax);
        k = ((u64_t'(1) << 60) + d / 2) / d;
        hi = ax >> 16;
        lo = ax & 64'hFFFF;
        t = 2 * hi * hi + ((2 * hi * lo * 65536 + lo * lo) >> 31);
        dens = qmul(exp_of_neg(t), K_INV_SQ2PI);
        p = K_A5;
        p = qmul_s(p, k) + K_A4;
        p = qmul_s(p, k) + K_A3;
        p = qmul_s(p, k) + K_A2;
        p = qmul_s(p, k) + K_A1;
        p = qmul_s(p, k);
        if (p < 0)
            p = 0;
        tail = qmul(u64_t'(p), dens);
        if (tail > ONE_Q)
            tail = ONE_Q;
        prob = neg ? tail : ONE_Q - tail;
        prob = (((prob << 1) >> (QW - FB)) + 1) >> 1;
        return prob[OW-1:0];
    endfunction

    int err_count = 0;

    task automatic report(string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    class cdf_scoreboard;
        logic [OW-1:0]        prob_q[$];
        logic signed [IW-1:0] arg_q[$];

        function void note_arg(logic signed [IW-1:0] x);
            prob_q.push_back(normal_cdf(x));
            arg_q.push_back(x);
        endfunction

        task check_prob(logic [OW-1:0] got);
            logic [OW-1:0]        want;
            logic signed [IW-1:0] x;
            if (prob_q.size() == 0)
            begin
                report($sformatf("unexpected probability %0d", got));
                return;
            end
            want = prob_q.pop_front();
            x = arg_q.pop_front();
            if (got !== want)
                report($sformatf("x=%0d probability %0d, want %0d", x, got, want));
        endtask

        function int pending();
            return prob_q.size();
        endfunction
    endclass

    cdf_scoreboard sb = new();

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic signed [IW-1:0] arg_x = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [OW-1:0]        probability;

    normal_cdf_approx_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .arg_x      (arg_x),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .probability(probability)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    bit quiet_mode = 0;   // stretch with no idling

    task automatic send_arg(logic signed [IW-1:0] x);
        int g;
        g = quiet_mode ? 0 : gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        arg_x <= x;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_arg(x);
    endtask

    // result side: sample at the edge, drive ready with NBA
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_prob(probability);
        if (quiet_mode)
            out_ready <= 1'b1;
        else
            out_ready <= ($urandom_range(0, 99) < 70) ? 1'b1
                       : ($urandom_range(0, 9) == 0 ? 1'b0 : ~out_ready);
    end

    function automatic logic signed [IW-1:0] rand_arg();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)   // main region, -4 <= x < 4
            return IW'($signed($urandom_range(0, 524287)) - 262144);
        if (r < 8)
            return IW'($urandom());
        return IW'($signed($urandom_range(0, 4096)) - 2048);
    endfunction

    initial
    begin
        logic signed [IW-1:0] directed[$];
        directed = '{
            20'sh00000, 20'sh00001, 20'shFFFFF, 20'sh7FFFF, 20'sh80000,
            20'sh80001, 20'sh10000, -20'sh10000, 20'sh20000, -20'sh20000,
            20'sh30000, -20'sh30000, 20'sh40000, -20'sh40000, 20'sh60000,
            -20'sh60000, 20'sh08000, -20'sh08000, 20'sh55555, 20'shAAAAA,
            20'sh00100, -20'sh00100, 20'sh5A000, -20'sh5A000
        };
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
            send_arg(directed[i]);
        for (int n = 0; n < 1400; n++)
        begin
            quiet_mode = (n >= 300 && n < 450);
            send_arg(rand_arg());
            if (n == 700)
            begin
                in_valid <= 1'b0;
                while (sb.pending() != 0)
                    @(posedge clk);
            end
        end
        quiet_mode = 0;
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (err_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: files.f
rtl/core/ncdf_pkg.sv
rtl/core/ncdf_div.sv
rtl/core/ncdf_exp.sv
rtl/core/normal_cdf_approx_core.sv
verif/tb_normal_cdf_approx_core.sv
